>>> sv/ccws_pkg.sv
`timescale 1ns / 1ps

package ccws_pkg;

    // result queue sizing
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);
    // room for an end-marked item, which pushes two results
    localparam logic [Q_CW-1:0] Q_ROOM_MAX = Q_CW'(Q_DEPTH - 2);

    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_USCORE = 8'h5F;
    localparam logic [7:0] CH_DOLLAR = 8'h24;

    typedef enum logic [1:0] {
        MODE_CODE = 2'd0,
        MODE_LINE = 2'd1,
        MODE_OPEN = 2'd2,
        MODE_BODY = 2'd3
    } t_scan_mode;

    typedef struct packed {
        logic [7:0] previous_char;
        logic [7:0] last_emitted;
        logic       inside_string;
        t_scan_mode scan_mode;
        logic [7:0] saved_previous;
    } t_scan_state;

    localparam t_scan_state SCAN_RESET = '{
        previous_char:  8'h00,
        last_emitted:   8'h00,
        inside_string:  1'b0,
        scan_mode:      MODE_CODE,
        saved_previous: 8'h00
    };

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       run_last;
        logic       stream_end;
    } t_result;

    typedef struct packed {
        logic    push_one;
        logic    push_two;
        t_result first;
        t_result second;
    } t_push;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        return (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
               (c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
    endfunction

    function automatic logic is_ident(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h61 && c <= 8'h7A) || (c == CH_USCORE) || (c == CH_DOLLAR);
    endfunction

    function automatic logic is_sep_nsq(input logic [7:0] c);
        return (c != CH_SQUOTE) &&
               (is_space(c) || ((c != CH_USCORE) && (c != CH_DOLLAR) && is_punct(c)));
    endfunction

endpackage

>>> sv/ccws_in_if.sv
`timescale 1ns / 1ps

interface ccws_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_in;

    modport source (output valid, output in_byte, output end_in, input ready);
    modport sink   (input valid, input in_byte, input end_in, output ready);
endinterface

>>> sv/ccws_out_if.sv
`timescale 1ns / 1ps

interface ccws_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       run_last;
    logic       stream_end;

    modport source (output valid, output out_byte, output has_byte, output run_last,
                    output stream_end, input ready);
    modport sink   (input valid, input out_byte, input has_byte, input run_last,
                    input stream_end, output ready);
endinterface

>>> sv/ccws_decide.sv
`timescale 1ns / 1ps

module ccws_decide
    import ccws_pkg::*;
(
    input  t_scan_state i_st,
    input  logic [7:0]  i_c,
    input  logic [7:0]  i_nx,
    input  logic        i_nx_valid,
    output t_scan_state o_st,
    output logic        o_kept,
    output logic [7:0]  o_byte
);

    logic [7:0] prev;
    logic       nx_ident;
    logic       instr;
    logic       drop;

    assign prev     = i_st.previous_char;
    assign nx_ident = i_nx_valid && is_ident(i_nx);

    always_comb begin
        o_st   = i_st;
        o_kept = 1'b0;
        o_byte = 8'h00;
        instr  = i_st.inside_string;
        drop   = 1'b0;
        case (i_st.scan_mode)
            MODE_LINE: begin
                if (i_nx_valid && i_nx == CH_LF) begin
                    o_st.scan_mode     = MODE_CODE;
                    o_st.previous_char = i_st.saved_previous;
                end
            end
            MODE_OPEN: begin
                // opening star swallowed, cannot pair with a following slash
                o_st.scan_mode     = MODE_BODY;
                o_st.previous_char = 8'h00;
            end
            MODE_BODY: begin
                if (i_c == CH_SLASH && prev == CH_STAR) begin
                    o_st.scan_mode = MODE_CODE;
                    if (is_ident(i_st.saved_previous) && nx_ident) begin
                        o_st.previous_char = CH_SPACE;
                        o_st.last_emitted  = CH_SPACE;
                        o_kept             = 1'b1;
                        o_byte             = CH_SPACE;
                    end else begin
                        o_st.previous_char = i_st.saved_previous;
                    end
                end else begin
                    o_st.previous_char = i_c;
                end
            end
            default: begin
                if (i_c == CH_DQUOTE) begin
                    if (instr) begin
                        if (prev != CH_BSLASH) instr = 1'b0;
                    end else if (!(prev == CH_SQUOTE && i_nx_valid && i_nx == CH_SQUOTE)) begin
                        instr = 1'b1;
                    end
                end
                o_st.inside_string = instr;
                if (!instr) begin
                    if (i_c == CH_SLASH && i_nx_valid && i_nx == CH_SLASH) begin
                        o_st.saved_previous = prev;
                        o_st.scan_mode      = MODE_LINE;
                        drop                = 1'b1;
                    end else if (i_c == CH_SLASH && i_nx_valid && i_nx == CH_STAR) begin
                        o_st.saved_previous = prev;
                        o_st.scan_mode      = MODE_OPEN;
                        drop                = 1'b1;
                    end else if (is_space(i_c) &&
                                 !(is_ident(i_st.last_emitted) && nx_ident)) begin
                        if ((i_c != CH_LF && (is_sep_nsq(prev) ||
                             (i_nx_valid && is_sep_nsq(i_nx)))) ||
                            prev == i_c || (i_nx_valid && i_nx == i_c)) begin
                            drop = 1'b1;
                        end
                    end
                end
                if (!drop) begin
                    o_st.previous_char = i_c;
                    o_st.last_emitted  = i_c;
                    o_kept             = 1'b1;
                    o_byte             = i_c;
                end
            end
        endcase
    end

endmodule

>>> sv/ccws_core.sv
`timescale 1ns / 1ps

module ccws_core
    import ccws_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    ccws_in_if.sink   i_in,
    input  logic      i_room,
    output t_push     o_push
);

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_end;
    logic [7:0]  r_held_char;
    logic        r_held_valid;
    t_scan_state r_state;

    logic        w_fire;
    logic        w_accept;
    t_scan_state w_st_a;
    t_scan_state w_st_mid;
    t_scan_state w_st_b;
    logic        w_kept_a;
    logic        w_kept_b;
    logic [7:0]  w_byte_a;
    logic [7:0]  w_byte_b;

    assign w_fire     = r_in_valid && i_room;
    assign i_in.ready = !r_in_valid || w_fire;
    assign w_accept   = i_in.valid && i_in.ready;

    // held byte decided against the incoming one
    ccws_decide u_dec_held (
        .i_st       (r_state),
        .i_c        (r_held_char),
        .i_nx       (r_in_byte),
        .i_nx_valid (1'b1),
        .o_st       (w_st_a),
        .o_kept     (w_kept_a),
        .o_byte     (w_byte_a)
    );

    assign w_st_mid = r_held_valid ? w_st_a : r_state;

    // final byte decided with no next character
    ccws_decide u_dec_last (
        .i_st       (w_st_mid),
        .i_c        (r_in_byte),
        .i_nx       (8'h00),
        .i_nx_valid (1'b0),
        .o_st       (w_st_b),
        .o_kept     (w_kept_b),
        .o_byte     (w_byte_b)
    );

    always_comb begin
        o_push.push_one          = w_fire;
        o_push.push_two          = w_fire && r_in_end;
        o_push.first.out_byte    = (r_held_valid && w_kept_a) ? w_byte_a : 8'h00;
        o_push.first.has_byte    = r_held_valid && w_kept_a;
        o_push.first.run_last    = !r_in_end;
        o_push.first.stream_end  = 1'b0;
        o_push.second.out_byte   = w_byte_b;
        o_push.second.has_byte   = w_kept_b;
        o_push.second.run_last   = 1'b1;
        o_push.second.stream_end = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_held_valid <= 1'b0;
            r_held_char  <= 8'h00;
            r_state      <= SCAN_RESET;
        end else begin
            if (w_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_fire) begin
                r_in_valid <= 1'b0;
            end
            if (w_fire) begin
                if (r_in_end) begin
                    r_held_valid <= 1'b0;
                    r_held_char  <= 8'h00;
                    r_state      <= SCAN_RESET;
                end else begin
                    r_held_valid <= 1'b1;
                    r_held_char  <= r_in_byte;
                    r_state      <= w_st_mid;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_byte <= i_in.in_byte;
            r_in_end  <= i_in.end_in;
        end
    end

`ifndef NO_ASSERTIONS
    a_end_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && r_in_end |=> !r_held_valid && r_state.scan_mode == MODE_CODE &&
                               !r_state.inside_string)
        else $error("end-marked beat did not return scanner to reset state");

    a_held_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire && !r_in_end |=> r_held_valid && r_held_char == $past(r_in_byte))
        else $error("held byte not taken from processed beat");

    a_in_reg_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_fire |=> r_in_valid && $stable(r_in_byte) && $stable(r_in_end))
        else $error("input register lost a waiting beat");
`endif

endmodule

>>> sv/ccws_res_queue.sv
`timescale 1ns / 1ps

module ccws_res_queue
    import ccws_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_push      i_push,
    output logic       o_room,
    ccws_out_if.source o_out
);

    t_result          r_mem [Q_DEPTH];
    logic [Q_AW-1:0]  r_wr;
    logic [Q_AW-1:0]  r_rd;
    logic [Q_CW-1:0]  r_count;
    logic [Q_CW-1:0]  n_count;
    logic             w_pop;
    logic [Q_AW-1:0]  w_wr_next;
    t_result          w_head;

    assign w_head           = r_mem[r_rd];
    assign o_out.valid      = (r_count != '0);
    assign o_out.out_byte   = w_head.out_byte;
    assign o_out.has_byte   = w_head.has_byte;
    assign o_out.run_last   = w_head.run_last;
    assign o_out.stream_end = w_head.stream_end;
    assign w_pop            = o_out.valid && o_out.ready;
    assign o_room           = (r_count <= Q_ROOM_MAX);
    assign w_wr_next        = r_wr + 1'b1;

    always_comb begin
        n_count = r_count + Q_CW'(i_push.push_one) + Q_CW'(i_push.push_two)
                  - Q_CW'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_count <= n_count;
            if (w_pop) r_rd <= r_rd + 1'b1;
            if (i_push.push_two) begin
                r_wr <= r_wr + Q_AW'(2);
            end else if (i_push.push_one) begin
                r_wr <= w_wr_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push_one) r_mem[r_wr] <= i_push.first;
        if (i_push.push_two) r_mem[w_wr_next] <= i_push.second;
    end

endmodule

>>> sv/c_comment_whitespace_stripper_unit.sv
`timescale 1ns / 1ps

// c++ comment and whitespace stripper: source bytes arrive one per beat on i_in
// (in_byte, end_in) and stripped results leave on o_out, one result per beat.
// each byte is decided only once the next byte is seen, so every input beat
// yields one result for the byte held before it (has_byte 0 when nothing was
// held or the byte was dropped); a beat with end_in set yields a second result
// for its own byte, carrying stream_end, and then the scanner starts afresh.
// throughput is one input beat per clock while the result queue has room; an
// end-marked beat pushes two results, which leave on o_out as two result beats.
// an input beat passes through one input register, then the decision logic
// writes straight into a four-entry result queue whose head drives o_out.
// input is held off only while the result queue lacks room for two results.
// no clearing pass after reset

module c_comment_whitespace_stripper_unit
    import ccws_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    ccws_in_if.sink    i_in,
    ccws_out_if.source o_out
);

    // push request from the scanner into the result queue
    t_push w_push;
    // queue can absorb a two-result beat
    logic  w_room;

    // input register, scanner state and the two chained byte decisions
    ccws_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_room  (w_room),
        .o_push  (w_push)
    );

    // result queue decouples output stalls from the input side
    ccws_res_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_room  (w_room),
        .o_out   (o_out)
    );

endmodule

>>> dv/c_comment_whitespace_stripper_unit_checker.sv
`timescale 1ns / 1ps

module c_comment_whitespace_stripper_unit_checker
    import ccws_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    ccws_in_if   i_in_mon,
    ccws_out_if  i_out_mon,
    output int   o_fail_count,
    output int   o_expect_count
);

    localparam int REPORT_LIMIT = 30;

    // scanner state, mirrors the block after reset
    logic [7:0] held_byte   = 8'h00;
    logic       held_ok     = 1'b0;
    logic [7:0] prior_byte  = 8'h00;
    logic [7:0] last_kept   = 8'h00;
    logic       in_literal  = 1'b0;
    t_scan_mode mode        = MODE_CODE;
    logic [7:0] saved_prior = 8'h00;

    t_result stripped_q[$];
    t_result head;
    int      fail_count = 0;
    logic    bad_beat;

    function automatic logic ws_cls(input logic [7:0] c);
        return c inside {[8'h09:8'h0D], CH_SPACE};
    endfunction

    function automatic logic word_cls(input logic [7:0] c);
        return c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A], CH_USCORE, CH_DOLLAR};
    endfunction

    // separator, with the single quote left out
    function automatic logic split_cls(input logic [7:0] c);
        if (c inside {CH_USCORE, CH_DOLLAR, CH_SQUOTE})
            return 1'b0;
        return ws_cls(c) ||
               (c inside {[8'h21:8'h2F], [8'h3A:8'h40], [8'h5B:8'h60], [8'h7B:8'h7E]});
    endfunction

    // decide byte c given its successor; nx_none means end of stream
    task automatic resolve(input logic [7:0] c, input logic [7:0] nx, input logic nx_none,
                           output logic kept, output logic [7:0] ch);
        logic [7:0] prev;
        logic       nx_word;
        logic       nx_split;
        prev     = prior_byte;
        kept     = 1'b0;
        ch       = 8'h00;
        nx_word  = !nx_none && word_cls(nx);
        nx_split = !nx_none && split_cls(nx);
        case (mode)
            MODE_LINE: begin
                if (!nx_none && nx == CH_LF) begin
                    mode       = MODE_CODE;
                    prior_byte = saved_prior;
                end
            end
            MODE_OPEN: begin
                // the opening star never pairs with a following slash
                mode       = MODE_BODY;
                prior_byte = 8'h00;
            end
            MODE_BODY: begin
                if (c == CH_SLASH && prev == CH_STAR) begin
                    mode = MODE_CODE;
                    if (word_cls(saved_prior) && nx_word) begin
                        prior_byte = CH_SPACE;
                        last_kept  = CH_SPACE;
                        ch         = CH_SPACE;
                        kept       = 1'b1;
                    end else begin
                        prior_byte = saved_prior;
                    end
                end else begin
                    prior_byte = c;
                end
            end
            default: begin
                if (c == CH_DQUOTE) begin
                    if (in_literal) begin
                        if (prev != CH_BSLASH)
                            in_literal = 1'b0;
                    end else if (!(prev == CH_SQUOTE && !nx_none && nx == CH_SQUOTE)) begin
                        in_literal = 1'b1;
                    end
                end
                kept = 1'b1;
                if (!in_literal) begin
                    if (c == CH_SLASH && !nx_none && (nx == CH_SLASH || nx == CH_STAR)) begin
                        saved_prior = prev;
                        if (nx == CH_SLASH)
                            mode = MODE_LINE;
                        else
                            mode = MODE_OPEN;
                        kept = 1'b0;
                    end else if (ws_cls(c) && !(word_cls(last_kept) && nx_word)) begin
                        if ((c != CH_LF && (split_cls(prev) || nx_split)) || prev == c ||
                            (!nx_none && nx == c))
                            kept = 1'b0;
                    end
                end
                if (kept) begin
                    prior_byte = c;
                    last_kept  = c;
                    ch         = c;
                end
            end
        endcase
    endtask

    task automatic strip_beat(input logic [7:0] b, input logic fin);
        logic       kept;
        logic [7:0] ch;
        kept = 1'b0;
        ch   = 8'h00;
        if (held_ok)
            resolve(held_byte, b, 1'b0, kept, ch);
        stripped_q.push_back('{out_byte: ch, has_byte: kept, run_last: !fin, stream_end: 1'b0});
        if (!fin) begin
            held_byte = b;
            held_ok   = 1'b1;
        end else begin
            resolve(b, 8'h00, 1'b1, kept, ch);
            stripped_q.push_back('{out_byte: ch, has_byte: kept, run_last: 1'b1,
                                   stream_end: 1'b1});
            held_byte   = 8'h00;
            held_ok     = 1'b0;
            prior_byte  = 8'h00;
            last_kept   = 8'h00;
            in_literal  = 1'b0;
            mode        = MODE_CODE;
            saved_prior = 8'h00;
        end
    endtask

    task automatic compare_field(input string field, input logic [7:0] want,
                                 input logic [7:0] got, inout logic bad);
        if (got !== want) begin
            if (fail_count < REPORT_LIMIT)
                $error("%s mismatch: expected %02h, actual %02h", field, want, got);
            bad = 1'b1;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_mon.valid && i_in_mon.ready)
                strip_beat(i_in_mon.in_byte, i_in_mon.end_in);
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (stripped_q.size() == 0) begin
                    if (fail_count < REPORT_LIMIT)
                        $error("unexpected result beat: out_byte %02h", i_out_mon.out_byte);
                    fail_count++;
                end else begin
                    head     = stripped_q.pop_front();
                    bad_beat = 1'b0;
                    compare_field("out_byte", head.out_byte, i_out_mon.out_byte, bad_beat);
                    compare_field("has_byte", 8'(head.has_byte), 8'(i_out_mon.has_byte),
                                  bad_beat);
                    compare_field("run_last", 8'(head.run_last), 8'(i_out_mon.run_last),
                                  bad_beat);
                    compare_field("stream_end", 8'(head.stream_end), 8'(i_out_mon.stream_end),
                                  bad_beat);
                    if (bad_beat)
                        fail_count++;
                end
            end
        end
        o_expect_count <= stripped_q.size();
        o_fail_count   <= fail_count;
    end

endmodule

>>> dv/c_comment_whitespace_stripper_unit_tb.sv
`timescale 1ns / 1ps

module c_comment_whitespace_stripper_unit_tb;
    import ccws_pkg::*;

    localparam int RANDOM_ITEMS   = 1350;
    // longest run of cycles with no beat on either side before giving up
    localparam int WATCHDOG_LIMIT = 2000;
    // settle time after the last expected result
    localparam int DRAIN_CYCLES   = 8;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always #5 i_clk = ~i_clk;

    ccws_in_if  src_bus ();
    ccws_out_if res_bus ();

    int fail_count;
    int expect_count;
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int items_sent         = 0;
    int quiet_cycles       = 0;

    // source bytes of the stream being built, sent in order, end mark on the last
    logic [7:0] stream_q[$];

    // idling per phase of the random part: none, sender, receiver, both, then again
    int idle_tbl[8]  = '{0, 73, 0, 22, 0, 73, 0, 22};
    int stall_tbl[8] = '{0, 0, 73, 22, 0, 0, 73, 22};

    c_comment_whitespace_stripper_unit u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (src_bus),
        .o_out   (res_bus)
    );

    c_comment_whitespace_stripper_unit_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_mon       (src_bus),
        .i_out_mon      (res_bus),
        .o_fail_count   (fail_count),
        .o_expect_count (expect_count)
    );

    initial begin
        src_bus.valid   = 1'b0;
        src_bus.in_byte = 8'h00;
        src_bus.end_in  = 1'b0;
        res_bus.ready   = 1'b0;
    end

    // receiver back-pressure, redrawn every cycle
    always @(posedge i_clk) begin
        res_bus.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
    end

    // watchdog: any beat on either channel resets the count
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((src_bus.valid && src_bus.ready) || (res_bus.valid && res_bus.ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    function automatic logic [7:0] word_byte();
        case ($urandom_range(0, 3))
            0:       return 8'(8'h61 + $urandom_range(0, 25));
            1:       return 8'(8'h41 + $urandom_range(0, 25));
            2:       return 8'(8'h30 + $urandom_range(0, 9));
            default: return $urandom_range(0, 1) ? CH_USCORE : CH_DOLLAR;
        endcase
    endfunction

    // tab, lf, vt, ff, cr or space, space a bit more often
    function automatic logic [7:0] ws_byte();
        int unsigned r;
        r = $urandom_range(0, 6);
        return (r >= 5) ? CH_SPACE : 8'(9 + r);
    endfunction

    function automatic void push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            stream_q.push_back(s[i]);
    endfunction

    // one lexical piece of c++ text, mostly well formed, sometimes broken
    task automatic add_token();
        string      punct_set = "(){}[];,+-=<>*/&|!.#%^~?:'\"\\";
        int         n;
        logic [7:0] w;
        case ($urandom_range(0, 15))
            0, 1, 2, 3: begin
                n = $urandom_range(1, 5);
                repeat (n) stream_q.push_back(word_byte());
            end
            4, 5: begin
                // runs of whitespace, often the same character repeated
                w = ws_byte();
                n = $urandom_range(1, 3);
                repeat (n) begin
                    stream_q.push_back(w);
                    if ($urandom_range(0, 1))
                        w = ws_byte();
                end
            end
            6, 7: stream_q.push_back(punct_set[$urandom_range(0, punct_set.len() - 1)]);
            8: begin
                // string literal with escaped quotes and comment look-alikes inside
                stream_q.push_back(CH_DQUOTE);
                n = $urandom_range(0, 5);
                repeat (n) begin
                    case ($urandom_range(0, 4))
                        0:       push_text("\\\"");
                        1:       stream_q.push_back(CH_SLASH);
                        2:       stream_q.push_back(CH_STAR);
                        3:       stream_q.push_back(word_byte());
                        default: stream_q.push_back(CH_SPACE);
                    endcase
                end
                if ($urandom_range(0, 7) != 0)
                    stream_q.push_back(CH_DQUOTE);
            end
            9: begin
                stream_q.push_back(CH_SQUOTE);
                case ($urandom_range(0, 2))
                    0:       stream_q.push_back(CH_DQUOTE);
                    1:       stream_q.push_back(CH_BSLASH);
                    default: stream_q.push_back(word_byte());
                endcase
                stream_q.push_back(CH_SQUOTE);
            end
            10: begin
                push_text("//");
                n = $urandom_range(0, 4);
                repeat (n) stream_q.push_back($urandom_range(0, 2) ? word_byte() : CH_SPACE);
                if ($urandom_range(0, 5) != 0)
                    stream_q.push_back(CH_LF);
            end
            11: begin
                push_text("/*");
                n = $urandom_range(0, 4);
                repeat (n) begin
                    case ($urandom_range(0, 4))
                        0:       stream_q.push_back(CH_STAR);
                        1:       stream_q.push_back(CH_SLASH);
                        2:       stream_q.push_back(CH_LF);
                        3:       stream_q.push_back(CH_SPACE);
                        default: stream_q.push_back(word_byte());
                    endcase
                end
                if ($urandom_range(0, 5) != 0)
                    push_text("*/");
            end
            12: begin
                case ($urandom_range(0, 3))
                    0:       push_text("/");
                    1:       push_text("*/");
                    2:       push_text("/*/");
                    default: push_text("\"");
                endcase
            end
            13: stream_q.push_back(8'($urandom_range(0, 255)));
            14: stream_q.push_back(CH_LF);
            default: stream_q.push_back($urandom_range(0, 3) ? 8'($urandom_range(128, 255))
                                                             : 8'h00);
        endcase
    endtask

    // mostly short streams, now and then one built to a target of one to three bytes
    task automatic build_stream();
        int target;
        target = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 30);
        while (stream_q.size() < target)
            add_token();
    endtask

    // one input beat, after a random idle gap; returns once the beat is taken
    task automatic send_beat(input logic [7:0] b, input logic fin);
        while ($urandom_range(0, 99) < sender_idle_pct) begin
            src_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        src_bus.valid   <= 1'b1;
        src_bus.in_byte <= b;
        src_bus.end_in  <= fin;
        @(posedge i_clk);
        while (!src_bus.ready)
            @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_stream();
        for (int i = 0; i < stream_q.size(); i++)
            send_beat(stream_q[i], i == stream_q.size() - 1);
        stream_q.delete();
    endtask

    initial begin
        int base;
        int phase;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: a lone all-ones byte as a whole stream
        stream_q.push_back(8'hFF);
        send_stream();
        // block comment whose opening star is followed by a slash, words on both sides
        push_text("x/*/*/y");
        send_stream();
        // quote inside a char literal, doubled spaces, line comment left open at the end
        push_text("'\"'  //q");
        send_stream();
        // escaped quote in a string, then high byte and a zero byte to close
        push_text("\"\\\"\"");
        stream_q.push_back(8'h80);
        stream_q.push_back(8'h00);
        send_stream();
        // repeated newlines between words, tab next to a space
        push_text("a \t\n\nb");
        send_stream();

        // random streams, idling changes only at stream boundaries
        base = items_sent;
        while (items_sent - base < RANDOM_ITEMS) begin
            phase = ((items_sent - base) * 8) / RANDOM_ITEMS;
            if (phase > 7)
                phase = 7;
            sender_idle_pct    = idle_tbl[phase];
            receiver_stall_pct = stall_tbl[phase];
            build_stream();
            send_stream();
        end
        src_bus.valid <= 1'b0;

        // the checker's count is registered, so wait for a clock edge before looking
        @(posedge i_clk);
        while (expect_count != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> sim.f
sv/ccws_pkg.sv
sv/ccws_in_if.sv
sv/ccws_out_if.sv
sv/ccws_decide.sv
sv/ccws_core.sv
sv/ccws_res_queue.sv
sv/c_comment_whitespace_stripper_unit.sv
dv/c_comment_whitespace_stripper_unit_checker.sv
dv/c_comment_whitespace_stripper_unit_tb.sv
